@@ hdl/vbd_pkg.sv @@
// Shared types and constants of the 2x2x2 box downsampler.
// Used by the scan, output buffer and top-level modules; depends on nothing.
`default_nettype none

package vbd_pkg;

  // Field and register widths
  localparam int VOXEL_W = 8;
  localparam int SUM_W   = 11;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int POS_Z_W = 9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_DEPTH  = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_VOL_WIDTH  = 9'd256;
  localparam logic [CFG_W-1:0] RST_VOL_HEIGHT = 9'd256;
  localparam logic [CFG_W-1:0] RST_VOL_DEPTH  = 9'd128;

  // Smallest extent that forms one cube along an axis
  localparam logic [CFG_W-1:0] MIN_EXTENT = 9'd2;

  // Classification of the voxel at the current scan position
  typedef struct packed {
    logic in_box;     // inside the even extent of every axis
    logic first;      // first voxel of its cube
    logic last;       // last voxel of its cube
    logic final_cube; // cube is the last of the volume
  } scan_flags_t;

  // One result beat
  typedef struct packed {
    logic [VOXEL_W-1:0] mean_value;
    logic               last_of_volume;
  } result_t;

endpackage : vbd_pkg

`default_nettype wire

@@ hdl/voxel_box_downsample_2x.sv @@
// Top level of the 2x2x2 box downsampler: scan, partial-sum store and result buffer.
// Depends on vbd_pkg, vbd_scan, vbd_ram and vbd_out_buf.
//
// Usage:
//   Voxels stream in on the in_ channel (valid/stall), raster order, x fastest.
//   One beat per cycle is taken while in_stall is low; each voxel needs one
//   read-add-write of a partial sum in the store, read in the accept cycle and
//   written back in the cycle after; a voxel that hits the entry still being
//   written gets the new sum forwarded. Mean beats pass the accumulate stage
//   and result buffer to out_; out_last_of_volume marks the volume's last cube.
//   A two-entry result buffer lets input continue while a result waits; in_stall
//   rises only when that buffer backs up under a stalled receiver.
//   Extents are to be written on the cfg_ port (always ready) while the block is
//   idle (not enforced); any write to a known index restarts the volume at its origin.
//   Reset restores the default extents and the origin; the store needs no clearing,
//   since every entry is written by the first voxel of its cube before it is used.
`default_nettype none

module voxel_box_downsample_2x #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [vbd_pkg::VOXEL_W-1:0]       in_voxel_value,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [vbd_pkg::VOXEL_W-1:0]       out_mean_value,
  output      logic                              out_last_of_volume,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [vbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vbd_pkg::CFG_W-1:0]         cfg_data
);

  import vbd_pkg::*;

  localparam int DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int AW    = $clog2(DEPTH);

  logic              accept;
  scan_flags_t       flags;
  logic [AW-1:0]     addr;
  logic              full_soon;

  logic              s1_valid_r, s1_first_r, s1_last_r, s1_final_r;
  logic [AW-1:0]     s1_addr_r;
  logic [VOXEL_W-1:0] s1_val_r;
  logic              fwd_hit_r;
  logic [SUM_W-1:0]  fwd_sum_r;
  logic [SUM_W-1:0]  ram_rdata, operand, s1_sum;
  result_t           push_data, out_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = full_soon;
  assign accept    = in_valid && !in_stall;

  vbd_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .flags     (flags),
    .addr      (addr)
  );

  vbd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (s1_sum),
    .re    (accept && flags.in_box),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // Accumulate stage: control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept && flags.in_box;
      fwd_hit_r  <= accept && flags.in_box && s1_valid_r && (s1_addr_r == addr);
    end
  end

  // Accumulate stage: payload, and the sum being written for forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first_r <= flags.first;
      s1_last_r  <= flags.last;
      s1_final_r <= flags.final_cube;
      s1_addr_r  <= addr;
      s1_val_r   <= in_voxel_value;
    end
    fwd_sum_r <= s1_sum;
  end

  // Replace on the first voxel of a cube, add otherwise
  assign operand = fwd_hit_r ? fwd_sum_r : ram_rdata;
  assign s1_sum  = s1_first_r ? SUM_W'(s1_val_r) : operand + SUM_W'(s1_val_r);

  assign push_data.mean_value     = s1_sum[SUM_W-1:3];
  assign push_data.last_of_volume = s1_final_r;

  vbd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r && s1_last_r),
    .push_data (push_data),
    .full_soon (full_soon),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_mean_value     = out_data.mean_value;
  assign out_last_of_volume = out_data.last_of_volume;

  a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(in_valid && !in_stall)) else $error("stage filled without a beat");
  a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_valid_r) else $error("forward without an item in the stage");
  a_fwd_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> (s1_addr_r == $past(s1_addr_r))) else $error("forward from another entry");

endmodule : voxel_box_downsample_2x

`default_nettype wire

@@ hdl/vbd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module vbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : vbd_ram

`default_nettype wire

@@ hdl/vbd_scan.sv @@
// Extent registers and raster position of the downsampler.
// Classifies each voxel and forms its partial-sum address; uses vbd_pkg.
`default_nettype none

module vbd_scan #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [vbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [vbd_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                step,
  output      vbd_pkg::scan_flags_t                flags,
  output      logic [$clog2((MAX_WIDTH/2)*(MAX_HEIGHT/2))-1:0] addr
);

  import vbd_pkg::*;

  localparam int COLS = MAX_WIDTH / 2;
  localparam int ROWS = MAX_HEIGHT / 2;
  localparam int AW   = $clog2(COLS * ROWS);
  localparam int PXW  = $clog2(MAX_WIDTH);
  localparam int PYW  = $clog2(MAX_HEIGHT);
  localparam int XCW  = $clog2(MAX_WIDTH + 1);
  localparam int YCW  = $clog2(MAX_HEIGHT + 1);
  localparam int EXW  = (XCW > CFG_W) ? XCW : CFG_W;
  localparam int EYW  = (YCW > CFG_W) ? YCW : CFG_W;
  localparam logic [AW-1:0]  COLS_A = AW'(COLS);
  localparam logic [EXW-1:0] MAX_X  = EXW'(MAX_WIDTH);
  localparam logic [EYW-1:0] MAX_Y  = EYW'(MAX_HEIGHT);

  logic [CFG_W-1:0]   vol_width_r, vol_height_r, vol_depth_r;
  logic [PXW-1:0]     pos_x_r, pos_x_nxt;
  logic [PYW-1:0]     pos_y_r, pos_y_nxt;
  logic [POS_Z_W-1:0] pos_z_r, pos_z_nxt;
  logic               cfg_hit;

  logic [EXW-1:0]     w_raw, w_eff, w_even, px_ext;
  logic [EYW-1:0]     h_raw, h_eff, h_even, py_ext;
  logic [CFG_W-1:0]   d_eff, d_even;
  logic               end_x, end_y, end_z;
  logic               in_box, first, last, edge_x, edge_y, edge_z;

  // Register writes; a write to a known index restarts the volume
  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_index) inside
      REG_VOL_WIDTH, REG_VOL_HEIGHT, REG_VOL_DEPTH: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_width_r  <= RST_VOL_WIDTH;
      vol_height_r <= RST_VOL_HEIGHT;
      vol_depth_r  <= RST_VOL_DEPTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOL_WIDTH:  vol_width_r  <= cfg_data;
        REG_VOL_HEIGHT: vol_height_r <= cfg_data;
        REG_VOL_DEPTH:  vol_depth_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective extents: at least one cube, at most the store size
  always_comb begin
    w_raw = EXW'(vol_width_r);
    h_raw = EYW'(vol_height_r);
    if (w_raw < EXW'(MIN_EXTENT))   w_eff = EXW'(MIN_EXTENT);
    else if (w_raw > MAX_X)         w_eff = MAX_X;
    else                            w_eff = w_raw;
    if (h_raw < EYW'(MIN_EXTENT))   h_eff = EYW'(MIN_EXTENT);
    else if (h_raw > MAX_Y)         h_eff = MAX_Y;
    else                            h_eff = h_raw;
    if (vol_depth_r < MIN_EXTENT)   d_eff = MIN_EXTENT;
    else                            d_eff = vol_depth_r;
    w_even = {w_eff[EXW-1:1], 1'b0};
    h_even = {h_eff[EYW-1:1], 1'b0};
    d_even = {d_eff[CFG_W-1:1], 1'b0};
  end

  // Classify the voxel at the current position
  always_comb begin
    px_ext = EXW'(pos_x_r);
    py_ext = EYW'(pos_y_r);
    in_box = (px_ext < w_even) && (py_ext < h_even) && (pos_z_r < d_even);
    first  = ~(pos_x_r[0] | pos_y_r[0] | pos_z_r[0]);
    last   = pos_x_r[0] & pos_y_r[0] & pos_z_r[0];
    edge_x = (px_ext == w_even - EXW'(1));
    edge_y = (py_ext == h_even - EYW'(1));
    edge_z = (pos_z_r == d_even - CFG_W'(1));
    flags.in_box     = in_box;
    flags.first      = first;
    flags.last       = last;
    flags.final_cube = last & edge_x & edge_y & edge_z;
  end

  // Partial-sum address of the cube: row of the output plane times the store width
  assign addr = AW'(pos_y_r[PYW-1:1]) * COLS_A + AW'(pos_x_r[PXW-1:1]);

  // Advance the raster position
  always_comb begin
    end_x = (px_ext == w_eff - EXW'(1));
    end_y = (py_ext == h_eff - EYW'(1));
    end_z = (pos_z_r == d_eff - CFG_W'(1));
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (step) begin
      if (!end_x) begin
        pos_x_nxt = pos_x_r + PXW'(1);
      end else begin
        pos_x_nxt = '0;
        if (!end_y) begin
          pos_y_nxt = pos_y_r + PYW'(1);
        end else begin
          pos_y_nxt = '0;
          pos_z_nxt = end_z ? '0 : pos_z_r + POS_Z_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

  // X position stays inside the effective width
  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    EXW'(pos_x_r) < w_eff) else $error("x position beyond width");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (pos_x_r == '0 && pos_y_r == '0 && pos_z_r == '0))
    else $error("register write did not restart the volume");
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    flags.final_cube |-> flags.last) else $error("final cube flag off a cube end");

endmodule : vbd_scan

`default_nettype wire

@@ hdl/vbd_out_buf.sv @@
// Two-entry result buffer between the accumulate stage and the output channel.
// Reports when it cannot take another in-flight result; uses vbd_pkg.
`default_nettype none

module vbd_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire vbd_pkg::result_t push_data,
  output      logic             full_soon,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      vbd_pkg::result_t out_data
);

  import vbd_pkg::*;

  result_t    head_r, head_nxt, tail_r, tail_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = head_r;
  assign pop       = out_valid && !out_stall;
  // No room for a beat accepted now, counting the one about to land
  assign full_soon = (count_r == 2'd2) || (count_r == 2'd1 && push);

  // Shift on pop, append on push
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    case ({pop, push})
      2'b11: begin
        if (count_r == 2'd1) begin
          head_nxt = push_data;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_data;
        end
      end
      2'b10: begin
        head_nxt  = tail_r;
        count_nxt = count_r - 2'd1;
      end
      2'b01: begin
        if (count_r == 2'd0) head_nxt = push_data;
        else                 tail_nxt = push_data;
        count_nxt = count_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !(count_r == 2'd2 && !pop)) else $error("result buffer overflow");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("result buffer count corrupt");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule : vbd_out_buf

`default_nettype wire
